// File: src/savitzky_golay_smoother_core_defines.svh
// ---------------------------------------------------------------------------
// Savitzky-Golay smoother assertion macros
// Shared concurrent assertion forms, synchronous reset disables checking.
// ---------------------------------------------------------------------------
`ifndef SAVITZKY_GOLAY_SMOOTHER_CORE_DEFINES_SVH
`define SAVITZKY_GOLAY_SMOOTHER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SGS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgs same-cycle check failed");

// Next-cycle implication.
`define SGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgs next-cycle check failed");

`endif

// File: src/sgs_pkg.sv
// ---------------------------------------------------------------------------
// sgs_pkg
// Types and constants of the five-point Savitzky-Golay smoother.
// ---------------------------------------------------------------------------
`default_nettype none

package sgs_pkg;

   localparam int WINDOW_LENGTH = 5;
   localparam int HIST_DEPTH    = WINDOW_LENGTH - 1;
   localparam int CENTER        = WINDOW_LENGTH / 2;
   localparam int SAMPLE_BITS   = 16;
   localparam int ACC_BITS      = 22;
   localparam int MAG_BITS      = ACC_BITS - 1;
   localparam int RECIP_SHIFT   = 26;
   localparam int PROD_BITS     = 2 * MAG_BITS;
   localparam int QMAG_BITS     = SAMPLE_BITS;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;
   typedef logic        [MAG_BITS-1:0]    mag_type;
   typedef logic        [PROD_BITS-1:0]   prod_type;
   typedef logic        [QMAG_BITS-1:0]   qmag_type;
   typedef sample_type                    taps_type [WINDOW_LENGTH];
   typedef sample_type                    hist_type [HIST_DEPTH];

   typedef struct packed {
      logic       advance;
      sample_type smoothed;
   } window_update_type;

   // weights, oldest tap first
   localparam acc_type SG_WEIGHTS [WINDOW_LENGTH] = '{
      -22'sd3, 22'sd12, 22'sd17, 22'sd12, -22'sd3
   };

   // ceil(2^26 / 35): exact floor division for magnitudes below 2^21
   localparam prod_type SG_RECIP = PROD_BITS'(1917397);

   localparam qmag_type SAT_POS_LIMIT = QMAG_BITS'(32767);
   localparam qmag_type SAT_NEG_LIMIT = QMAG_BITS'(32768);
   localparam sample_type SAMPLE_MAX  = 16'sh7fff;
   localparam sample_type SAMPLE_MIN  = 16'sh8000;

endpackage

`default_nettype wire

// File: src/sgs_filter.sv
// ---------------------------------------------------------------------------
// sgs_filter
// Weighted window sum, truncating divide by 35 and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module sgs_filter
   import sgs_pkg::*;
(
   input  wire taps_type   taps,
   output sample_type      smoothed
);

   acc_type  acc;
   mag_type  mag;
   prod_type prod;
   qmag_type qmag;
   logic     neg;

   always_comb begin
      acc = '0;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
         acc = acc + ACC_BITS'(taps[i]) * SG_WEIGHTS[i];
      end
   end

   assign neg  = acc[ACC_BITS-1];
   assign mag  = neg ? MAG_BITS'(-acc) : MAG_BITS'(acc);
   assign prod = PROD_BITS'(mag) * SG_RECIP;
   assign qmag = prod[RECIP_SHIFT +: QMAG_BITS];

   always_comb begin
      if (!neg) begin
         smoothed = (qmag > SAT_POS_LIMIT) ? SAMPLE_MAX : sample_type'(qmag);
      end else begin
         smoothed = (qmag > SAT_NEG_LIMIT) ? SAMPLE_MIN : sample_type'(-qmag);
      end
   end

endmodule

`default_nettype wire

// File: src/sgs_window.sv
// ---------------------------------------------------------------------------
// sgs_window
// Sample history; holds the four older window entries and writes back
// the smoothed value into the centre entry.
// ---------------------------------------------------------------------------
`default_nettype none

module sgs_window
   import sgs_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  window_update_type upd,
   input  wire sample_type   sample,
   output taps_type          taps
);

   hist_type hist_ff;
   hist_type hist_in;

   always_comb begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
         taps[i] = hist_ff[i];
      end
      taps[HIST_DEPTH] = sample;
   end

   always_comb begin
      hist_in = hist_ff;
      if (upd.advance) begin
         for (int i = 0; i < HIST_DEPTH - 1; i++) begin
            hist_in[i] = hist_ff[i+1];
         end
         hist_in[HIST_DEPTH-1] = sample;
         hist_in[CENTER-1]     = upd.smoothed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         hist_ff <= hist_in;
      end
   end

endmodule

`default_nettype wire

// File: src/savitzky_golay_smoother_core.sv
// ---------------------------------------------------------------------------
// savitzky_golay_smoother_core
// Five-point quadratic smoother with output feedback into the window.
// ---------------------------------------------------------------------------
// Takes one signed 16-bit sample per transaction and returns one smoothed
// sample per transaction, in order. Throughput is one transaction per clock
// while rsp is not stalled. A sample lands in the input register at the edge
// that accepts it, and the result register loads when that sample advances,
// which a stall on rsp holds off; the result is then offered on rsp. The rate
// is set by the window feedback loop: window registers, weighted sum,
// reciprocal multiply for the divide by 35 and saturation close in one
// combinational path. The window is zero after reset.
`default_nettype none
`include "savitzky_golay_smoother_core_defines.svh"

module savitzky_golay_smoother_core
   import sgs_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [15:0] req_tdata,   // [15:0] sample
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [15:0] rsp_tdata   // [15:0] smoothed
);

   logic              in_valid_ff,  in_valid_in;
   sample_type        sample_ff,    sample_in;
   logic              out_valid_ff, out_valid_in;
   sample_type        result_ff,    result_in;
   logic              advance;
   taps_type          taps;
   window_update_type upd;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign sample_in    = (req_tvalid && req_tready) ? sample_type'(req_tdata) : sample_ff;
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   assign upd.advance  = advance;
   assign upd.smoothed = result_in;

   sgs_window u_window (
      .clock  (clock),
      .reset  (reset),
      .upd    (upd),
      .sample (sample_ff),
      .taps   (taps)
   );

   sgs_filter u_filter (
      .taps     (taps),
      .smoothed (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = result_ff;

   `SGS_ASSERT_NEXT(a_adv_result, clock, reset, advance, out_valid_ff && result_ff == $past(result_in))
   `SGS_ASSERT_NEXT(a_stall_hold, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(sample_ff))
   `SGS_ASSERT_NEXT(a_feedback, clock, reset, advance, taps[CENTER-1] == $past(result_in))
   `SGS_ASSERT_NOW(a_empty_ready, clock, reset, !out_valid_ff, req_tready)

endmodule

`default_nettype wire

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for savitzky_golay_smoother_core. Samples go in on the
// req stream; a local model of the five-tap window with output feedback
// predicts every smoothed value, and each rsp transaction is compared in
// order. Covers start from a zero window, full-scale steps that clamp the
// quotient, truncation of small negative sums, a long output stall that
// backs up the input, and a random stream with and without idle cycles.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sgs_pkg::sample_type;
   import sgs_pkg::SAMPLE_MAX;
   import sgs_pkg::SAMPLE_MIN;

   localparam int DIVISOR         = 35;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASE_SAMPLES   = 400;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [15:0] rsp_tdata;

   // window, oldest first; centre tap holds the previous result
   sample_type taps [5] = '{default: '0};
   sample_type smoothed_queue [$];

   int error_count        = 0;
   int sample_count       = 0;
   int result_count       = 0;
   int clamp_high_count   = 0;
   int clamp_low_count    = 0;
   int input_stall_cycles = 0;
   bit sender_gaps        = 1'b0;
   bit sink_gaps          = 1'b0;
   bit hold_request       = 1'b0;

   savitzky_golay_smoother_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] sample
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [15:0] smoothed
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic sample_type smooth_next(input sample_type s);
      longint acc;
      longint q;
      int     i;
      for (i = 0; i < 4; i++) taps[i] = taps[i + 1];
      taps[4] = s;
      acc = 17 * longint'(taps[2])
          + 12 * (longint'(taps[1]) + longint'(taps[3]))
          -  3 * (longint'(taps[0]) + longint'(taps[4]));
      q = acc / DIVISOR;   // truncates toward zero
      if (q > longint'(SAMPLE_MAX)) begin
         q = longint'(SAMPLE_MAX);
         clamp_high_count++;
      end else if (q < longint'(SAMPLE_MIN)) begin
         q = longint'(SAMPLE_MIN);
         clamp_low_count++;
      end
      taps[2] = sample_type'(q);
      return taps[2];
   endfunction

   task automatic send_sample(input sample_type s);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      smoothed_queue.push_back(smooth_next(s));
      sample_count++;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         gap = $urandom_range(1, 10);
         repeat (gap) @(posedge clock);
      end
   endtask

   // first samples meet an all-zero window
   task automatic test_startup;
      send_sample(SAMPLE_MAX);
      send_sample(16'sd0);
      send_sample(16'sd0);
      send_sample(-16'sd1);
   endtask

   // steady full scale, then a jump to the opposite rail overshoots the range
   task automatic test_full_scale;
      int k;
      for (k = 0; k < 5; k++) send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      for (k = 0; k < 5; k++) send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
   endtask

   // small negative sums round toward zero
   task automatic test_truncation;
      int k;
      for (k = 0; k < 5; k++) send_sample(16'sd0);
      send_sample(-16'sd1);
      send_sample(-16'sd12);
      send_sample(-16'sd35);
      send_sample(-16'sd1);
   endtask

   // output held off long enough that the core must stall its input
   task automatic test_input_backpressure;
      int k;
      hold_request = 1'b1;
      for (k = 0; k < 40; k++) send_sample(sample_type'($urandom));
   endtask

   task automatic test_random_stream(input int count);
      int         sent;
      int         run;
      int         k;
      sample_type level;
      sample_type s;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 19) == 0) begin
            // rail-to-rail step after a settled run
            level = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            run   = $urandom_range(4, 8);
            for (k = 0; k < run; k++) send_sample(level);
            send_sample(~level);
            sent += run + 1;
         end else begin
            case ($urandom_range(0, 9))
               5:       s = SAMPLE_MAX;
               6:       s = SAMPLE_MIN;
               7, 8:    s = sample_type'($urandom_range(0, 128) - 64);
               default: s = sample_type'($urandom);
            endcase
            send_sample(s);
            sent++;
         end
      end
   endtask

   initial begin : sink_control
      int stretch;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            stretch = $urandom_range(1, 10);
            repeat (stretch) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      sample_type expected;
      if (!reset) begin
         if (req_tvalid && !req_tready) input_stall_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (smoothed_queue.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transaction, expected none, actual %0d",
                        $time, sample_type'(rsp_tdata));
            end else begin
               expected = smoothed_queue.pop_front();
               if (sample_type'(rsp_tdata) !== expected) begin
                  error_count++;
                  $display("%0t: smoothed mismatch, expected %0d, actual %0d",
                           $time, expected, sample_type'(rsp_tdata));
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, smoothed_queue.size());
      $display("savitzky_golay_smoother_core: mismatch");
      $finish;
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_startup();
      test_full_scale();
      test_truncation();
      test_input_backpressure();

      sender_gaps = 1'b1;
      sink_gaps   = 1'b1;
      test_random_stream(PHASE_SAMPLES);
      sink_gaps   = 1'b0;
      test_random_stream(PHASE_SAMPLES);
      sender_gaps = 1'b0;
      sink_gaps   = 1'b1;
      test_random_stream(PHASE_SAMPLES);
      sink_gaps   = 1'b0;
      test_random_stream(PHASE_SAMPLES);

      req_tvalid <= 1'b0;
      while (smoothed_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d samples, checked %0d smoothed values; quotient clamped high %0d, low %0d",
               sample_count, result_count, clamp_high_count, clamp_low_count);
      $display("input held off for %0d cycles under output stalls; %0d errors",
               input_stall_cycles, error_count);
      if (error_count == 0)
         $display("savitzky_golay_smoother_core: match");
      else
         $display("savitzky_golay_smoother_core: mismatch");
      $finish;
   end

endmodule
